// ----- rtl/ilid_pkg.sv -----
// ----------------------------------------------------------------------------
// ilid_pkg
// Shared widths and codes for the indexed list insert/delete block.
// ----------------------------------------------------------------------------
`default_nettype none

package ilid_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned POS_W  = 8;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned STS_W  = 2;
    localparam int unsigned CNT_W  = 7;

    typedef logic [OP_W-1:0]          op_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic [STS_W-1:0]         sts_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    // operation codes
    localparam op_t OP_APPEND = 3'd0;
    localparam op_t OP_INSERT = 3'd1;
    localparam op_t OP_DELETE = 3'd2;
    localparam op_t OP_GET    = 3'd3;
    localparam op_t OP_SET    = 3'd4;

    // status codes
    localparam sts_t ST_OK    = 2'd0;
    localparam sts_t ST_FULL  = 2'd1;
    localparam sts_t ST_RANGE = 2'd2;

    // data word returned on any error
    localparam word_t ERR_WORD = '1;

endpackage

`default_nettype wire

// ----- rtl/ilid_if.sv -----
// ----------------------------------------------------------------------------
// ilid_if
// Request and response channels of the indexed list block.
// ----------------------------------------------------------------------------
`default_nettype none

interface ilid_req_if;
    import ilid_pkg::*;

    logic  valid;
    logic  ready;
    op_t   operation;
    pos_t  position;
    word_t value;

    modport source (output valid, output operation, output position, output value,
                    input ready);
    modport sink   (input valid, input operation, input position, input value,
                    output ready);
endinterface

interface ilid_rsp_if;
    import ilid_pkg::*;

    logic  valid;
    logic  ready;
    word_t data;
    sts_t  status;
    cnt_t  count;

    modport source (output valid, output data, output status, output count,
                    input ready);
    modport sink   (input valid, input data, input status, input count,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/ilid_ram.sv -----
// ----------------------------------------------------------------------------
// ilid_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/indexed_list_insert_delete.sv -----
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Bounded ordered list of signed words with append, insert, delete, get, set.
// ----------------------------------------------------------------------------
// The list lives in one simple dual-port RAM (one write, one registered read
// per cycle); a small sequencer walks it one entry per cycle with a single
// shared index adder. The block takes one request at a time and drops ready
// until the result is loaded into the output register. Insert and delete
// shift the entries behind the position, so the longest request shifts the
// whole list, one entry per cycle through the RAM's single read and single
// write port. Errors (full list, position out of range, unknown operation)
// return status with data all ones and leave the list unchanged. The count
// field carries the low 7 bits of the entry count. The next request is
// accepted while a finished result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_delete #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ilid_req_if.sink    req,
    ilid_rsp_if.source  rsp
);
    import ilid_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);   // entry count width
    localparam int unsigned AW = $clog2(CAPACITY);       // RAM address width
    localparam int unsigned EW = ((CW > POS_W) ? CW : POS_W) + 1;  // compare width

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WRITE  = 3'd1;
    localparam logic [2:0] S_GET    = 3'd2;
    localparam logic [2:0] S_GETW   = 3'd3;
    localparam logic [2:0] S_MOVE   = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    // control state
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pend_reg, pend_next;      // read issued last cycle, write due
    logic          ovld_reg, ovld_next;

    // working registers
    op_t           op_reg, op_next;
    pos_t          pos_reg, pos_next;
    word_t         val_reg, val_next;
    sts_t          sts_reg, sts_next;
    word_t         res_reg, res_next;
    logic [CW-1:0] src_reg, src_next;        // next entry to read while shifting
    logic [CW-1:0] dst_reg, dst_next;        // slot that entry src moves into
    logic [CW-1:0] dpipe_reg, dpipe_next;    // write address of the pending move
    logic [CW-1:0] left_reg, left_next;      // moves still to issue

    // output register
    word_t         odata_reg, odata_next;
    sts_t          osts_reg, osts_next;
    cnt_t          ocnt_reg, ocnt_next;

    // RAM port
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // request checks
    logic [EW-1:0]   req_pos_e;
    logic [EW-1:0]   cnt_e;
    logic            full;
    sts_t            chk_sts;
    logic [CW-1:0]   req_pos_cw;
    logic [CW-1:0]   pos_cw;
    logic [CW-1:0]   src_step;               // shared index adder
    logic [CW-1:0]   cnt_upd;
    logic [CW+6:0]   cnt_ext;
    logic            out_free;

    ilid_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshake and output side
    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = ovld_reg;
    assign rsp.data   = odata_reg;
    assign rsp.status = osts_reg;
    assign rsp.count  = ocnt_reg;

    assign out_free = !ovld_reg || rsp.ready;

    // range and capacity checks on the incoming beat
    assign req_pos_e  = EW'(req.position);
    assign cnt_e      = EW'(cnt_reg);
    assign full       = (cnt_reg == CW'(CAPACITY));
    assign req_pos_cw = CW'(req.position);
    assign pos_cw     = CW'(pos_reg);

    always_comb
    begin
        unique case (req.operation)
            OP_APPEND: chk_sts = full ? ST_FULL : ST_OK;
            OP_INSERT:
            begin
                if (full)
                begin
                    chk_sts = ST_FULL;
                end
                else if (req_pos_e > cnt_e)
                begin
                    chk_sts = ST_RANGE;
                end
                else
                begin
                    chk_sts = ST_OK;
                end
            end
            OP_DELETE, OP_GET, OP_SET:
                chk_sts = (req_pos_e >= cnt_e) ? ST_RANGE : ST_OK;
            default:   chk_sts = ST_RANGE;
        endcase
    end

    // insert walks downward, delete walks upward
    assign src_step = (op_reg == OP_INSERT) ? (src_reg - CW'(1)) : (src_reg + CW'(1));

    // entry count after the current request
    always_comb
    begin
        cnt_upd = cnt_reg;
        if (sts_reg == ST_OK)
        begin
            if (op_reg == OP_APPEND || op_reg == OP_INSERT)
            begin
                cnt_upd = cnt_reg + CW'(1);
            end
            else if (op_reg == OP_DELETE)
            begin
                cnt_upd = cnt_reg - CW'(1);
            end
        end
    end

    assign cnt_ext = {7'd0, cnt_upd};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pend_next  = 1'b0;
        ovld_next  = ovld_reg;
        op_next    = op_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        sts_next   = sts_reg;
        res_next   = res_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        dpipe_next = dpipe_reg;
        left_next  = left_reg;
        odata_next = odata_reg;
        osts_next  = osts_reg;
        ocnt_next  = ocnt_reg;

        ram_we    = 1'b0;
        ram_waddr = dst_reg[AW-1:0];
        ram_wdata = val_reg;
        ram_raddr = src_reg[AW-1:0];

        // output beat taken
        if (ovld_reg && rsp.ready)
        begin
            ovld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next  = req.operation;
                    pos_next = req.position;
                    val_next = req.value;
                    sts_next = chk_sts;
                    if (chk_sts != ST_OK)
                    begin
                        res_next   = ERR_WORD;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        unique case (req.operation)
                            OP_APPEND:
                            begin
                                dst_next   = cnt_reg;
                                state_next = S_WRITE;
                            end
                            OP_SET:
                            begin
                                dst_next   = req_pos_cw;
                                state_next = S_WRITE;
                            end
                            OP_INSERT:
                            begin
                                src_next   = cnt_reg - CW'(1);
                                dst_next   = cnt_reg;
                                left_next  = cnt_reg - req_pos_cw;
                                state_next = S_MOVE;
                            end
                            default:
                            begin
                                // get and delete read the addressed entry first
                                state_next = S_GET;
                            end
                        endcase
                    end
                end
            end

            S_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = dst_reg[AW-1:0];
                ram_wdata  = val_reg;
                res_next   = val_reg;
                state_next = S_RESULT;
            end

            S_GET:
            begin
                ram_raddr  = pos_cw[AW-1:0];
                state_next = S_GETW;
            end

            S_GETW:
            begin
                res_next = ram_rdata;
                if (op_reg == OP_DELETE)
                begin
                    src_next   = pos_cw + CW'(1);
                    dst_next   = pos_cw;
                    left_next  = cnt_reg - pos_cw - CW'(1);
                    state_next = S_MOVE;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end

            S_MOVE:
            begin
                // finish the move whose read was issued last cycle
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = dpipe_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                if (left_reg != '0)
                begin
                    ram_raddr  = src_reg[AW-1:0];
                    pend_next  = 1'b1;
                    dpipe_next = dst_reg;
                    dst_next   = src_reg;
                    src_next   = src_step;
                    left_next  = left_reg - CW'(1);
                end
                else if (op_reg == OP_INSERT)
                begin
                    // gap is open at the position, drop the new word in
                    dst_next   = pos_cw;
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    ovld_next  = 1'b1;
                    odata_next = res_reg;
                    osts_next  = sts_reg;
                    ocnt_next  = cnt_ext[CNT_W-1:0];
                    cnt_next   = cnt_upd;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            ovld_reg  <= ovld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        sts_reg   <= sts_next;
        res_reg   <= res_next;
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        dpipe_reg <= dpipe_next;
        left_reg  <= left_next;
        odata_reg <= odata_next;
        osts_reg  <= osts_next;
        ocnt_reg  <= ocnt_next;
    end

`ifndef SYNTHESIS
    // entry count never passes capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // a pending move write only happens while shifting
    a_pend_move: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_MOVE))
        else $error("move write outside shift phase");

    // one request at a time: ready drops right after an accepted beat
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second request taken while busy");

    // an error beat always carries the all-ones word
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.data == ERR_WORD))
        else $error("error beat without all-ones data");
`endif

endmodule

`default_nettype wire

// ----- tb/indexed_list_insert_delete_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_tb
// Self-checking bench for the bounded indexed list block. A short table of
// directed requests covers the empty and full list, the field extremes, every
// operation and the error paths. A long run of random requests follows, leaning
// toward growing, shrinking or mixed traffic in turn, under random gaps and
// backpressure. Every response beat is checked against the model or a known row.
// ----------------------------------------------------------------------------

module indexed_list_insert_delete_tb;
    import ilid_pkg::*;

    localparam int LIST_CAP     = 64;
    localparam int RANDOM_ITEMS = 1600;
    localparam int DIR_ROWS     = 27;
    localparam int DRAIN_CYCLES = LIST_CAP + 16;

    // operation codes the block has no use for
    localparam op_t OP_RSVD5 = 3'd5;
    localparam op_t OP_RSVD6 = 3'd6;
    localparam op_t OP_RSVD7 = 3'd7;

    // traffic mix of the random part
    typedef enum int {LEAN_GROW, LEAN_SHRINK, LEAN_EVEN} lean_t;

    // response-side ready patterns
    typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_HALF, RDY_SPARSE} rdy_mode_t;

    typedef struct packed {
        word_t data;
        sts_t  status;
        cnt_t  count;
    } list_rsp_t;

    // one directed row: request, repeat count, and a hand-written response
    // where the outcome is obvious (known = 1); otherwise the list model decides
    typedef struct packed {
        op_t        op;
        pos_t       pos;
        word_t      value;
        logic [6:0] reps;
        logic       known;
        word_t      data;
        sts_t       status;
        cnt_t       count;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ilid_req_if req_ch ();
    ilid_rsp_if rsp_ch ();

    indexed_list_insert_delete #(
        .CAPACITY (LIST_CAP)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // list model: contents, length and the responses still owed by the block
    // ------------------------------------------------------------------------
    word_t     list_words [LIST_CAP];
    int        list_len;
    list_rsp_t pending_rsp [$];
    list_rsp_t rsp_want;
    int        fail_count;
    int        burst_left;

    function automatic list_rsp_t apply_request(input op_t op, input pos_t pos,
                                                input word_t val);
        list_rsp_t r;
        r.data   = ERR_WORD;
        r.status = ST_RANGE;
        case (op)
            OP_APPEND:
            begin
                if (list_len >= LIST_CAP)
                    r.status = ST_FULL;
                else
                begin
                    list_words[list_len] = val;
                    list_len++;
                    r.data   = val;
                    r.status = ST_OK;
                end
            end
            OP_INSERT:
            begin
                // full check wins over the position check
                if (list_len >= LIST_CAP)
                    r.status = ST_FULL;
                else if (int'(pos) <= list_len)
                begin
                    for (int i = list_len; i > int'(pos); i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = val;
                    list_len++;
                    r.data   = val;
                    r.status = ST_OK;
                end
            end
            OP_DELETE:
            begin
                if (int'(pos) < list_len)
                begin
                    r.data = list_words[pos];
                    for (int i = int'(pos); i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    r.status = ST_OK;
                end
            end
            OP_GET:
            begin
                if (int'(pos) < list_len)
                begin
                    r.data   = list_words[pos];
                    r.status = ST_OK;
                end
            end
            OP_SET:
            begin
                if (int'(pos) < list_len)
                begin
                    list_words[pos] = val;
                    r.data   = val;
                    r.status = ST_OK;
                end
            end
            default:
            begin
                // unknown operation: list untouched, out-of-range status
            end
        endcase
        r.count = cnt_t'(list_len);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // request driver: bursts of back-to-back beats with random gaps between
    // ------------------------------------------------------------------------
    task automatic send_request(input op_t op, input pos_t pos, input word_t val,
                                input logic known, input list_rsp_t known_rsp);
        int        gap;
        list_rsp_t model_rsp;
        if (burst_left == 0)
        begin
            // now and then a long burst, so there are stretches with no idling
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.position  <= pos;
        req_ch.value     <= val;
        // valid is high from the next edge on; wait for the accepting edge
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        // beat accepted: update the model right away so the next pick sees it
        model_rsp = apply_request(op, pos, val);
        pending_rsp.push_back(known ? known_rsp : model_rsp);
        burst_left--;
    endtask

    // random request shaped by the current list length and traffic lean
    task automatic pick_request(input int len, input lean_t lean, output op_t op,
                                output pos_t pos, output word_t val);
        int r;
        int span;
        r = $urandom_range(0, 99);
        if (r < 3)
            op = op_t'($urandom_range(OP_RSVD5, OP_RSVD7));
        else
        begin
            case (lean)
                LEAN_GROW:
                    op = (r < 33) ? OP_APPEND : (r < 68) ? OP_INSERT :
                         (r < 78) ? OP_DELETE : (r < 89) ? OP_GET : OP_SET;
                LEAN_SHRINK:
                    op = (r < 11) ? OP_APPEND : (r < 21) ? OP_INSERT :
                         (r < 71) ? OP_DELETE : (r < 86) ? OP_GET : OP_SET;
                default:
                    op = (r < 22) ? OP_APPEND : (r < 42) ? OP_INSERT :
                         (r < 62) ? OP_DELETE : (r < 81) ? OP_GET : OP_SET;
            endcase
        end

        // mostly in-range positions, some right at the boundary, some anywhere
        r    = $urandom_range(0, 99);
        span = (op == OP_INSERT) ? len : len - 1;
        if (op == OP_APPEND)
            pos = pos_t'($urandom);
        else if (r < 85 && span >= 0)
            pos = pos_t'($urandom_range(0, span));
        else if (r < 92)
            pos = pos_t'(len);
        else
            pos = pos_t'($urandom_range(0, 255));

        case ($urandom_range(0, 11))
            0:       val = 32'sh7FFF_FFFF;
            1:       val = 32'sh8000_0000;
            2:       val = '0;
            3:       val = '1;
            default: val = word_t'($urandom);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------------
    dir_row_t directed_rows [DIR_ROWS] = '{
        // empty list after reset: every positional access is out of range
        '{OP_GET,    8'd0,   32'sd0,         7'd1,  1'b1, ERR_WORD, ST_RANGE, 7'd0},
        '{OP_DELETE, 8'd0,   32'sd0,         7'd1,  1'b1, ERR_WORD, ST_RANGE, 7'd0},
        '{OP_SET,    8'd0,   32'sd5,         7'd1,  1'b1, ERR_WORD, ST_RANGE, 7'd0},
        '{OP_INSERT, 8'd1,   32'sd5,         7'd1,  1'b1, ERR_WORD, ST_RANGE, 7'd0},
        // insert at position 0 of an empty list, appends with extreme words
        '{OP_INSERT, 8'd0,   32'sh7FFF_FFFF, 7'd1,  1'b1, 32'sh7FFF_FFFF, ST_OK, 7'd1},
        '{OP_APPEND, 8'hFF,  32'sh8000_0000, 7'd1,  1'b1, 32'sh8000_0000, ST_OK, 7'd2},
        '{OP_APPEND, 8'd0,   32'shFFFF_FFFF, 7'd1,  1'b1, 32'shFFFF_FFFF, ST_OK, 7'd3},
        // insert at position equal to the count acts as an append
        '{OP_INSERT, 8'd3,   32'sh1234_5678, 7'd1,  1'b1, 32'sh1234_5678, ST_OK, 7'd4},
        '{OP_INSERT, 8'd1,   32'sd0,         7'd1,  1'b1, 32'sd0,         ST_OK, 7'd5},
        '{OP_GET,    8'd4,   32'sd0,         7'd1,  1'b0, '0, ST_OK, '0},
        '{OP_GET,    8'd5,   32'sd0,         7'd1,  1'b1, ERR_WORD, ST_RANGE, 7'd5},
        '{OP_DELETE, 8'hFF,  32'sd0,         7'd1,  1'b1, ERR_WORD, ST_RANGE, 7'd5},
        '{OP_SET,    8'd2,   32'shA5A5_A5A5, 7'd1,  1'b1, 32'shA5A5_A5A5, ST_OK, 7'd5},
        // unused operation codes are rejected and leave the list alone
        '{OP_RSVD5,  8'd0,   32'sd1,         7'd1,  1'b1, ERR_WORD, ST_RANGE, 7'd5},
        '{OP_RSVD6,  8'd1,   32'sd2,         7'd1,  1'b1, ERR_WORD, ST_RANGE, 7'd5},
        '{OP_RSVD7,  8'hFF,  32'sd3,         7'd1,  1'b1, ERR_WORD, ST_RANGE, 7'd5},
        // delete at the head and at the tail
        '{OP_DELETE, 8'd0,   32'sd0,         7'd1,  1'b0, '0, ST_OK, '0},
        '{OP_DELETE, 8'd3,   32'sd0,         7'd1,  1'b0, '0, ST_OK, '0},
        // fill to capacity
        '{OP_APPEND, 8'd0,   32'sh0000_1000, 7'd61, 1'b0, '0, ST_OK, '0},
        // full list: the full check comes before the position check
        '{OP_APPEND, 8'd0,   32'sd1,         7'd1,  1'b1, ERR_WORD, ST_FULL, 7'd64},
        '{OP_INSERT, 8'hFF,  32'sd1,         7'd1,  1'b1, ERR_WORD, ST_FULL, 7'd64},
        '{OP_INSERT, 8'd0,   32'sd1,         7'd1,  1'b1, ERR_WORD, ST_FULL, 7'd64},
        '{OP_DELETE, 8'd63,  32'sd0,         7'd1,  1'b0, '0, ST_OK, '0},
        '{OP_INSERT, 8'd63,  32'sh0BAD_F00D, 7'd1,  1'b1, 32'sh0BAD_F00D, ST_OK, 7'd64},
        '{OP_GET,    8'd63,  32'sd0,         7'd1,  1'b1, 32'sh0BAD_F00D, ST_OK, 7'd64},
        // drain from the head, the longest shifts
        '{OP_DELETE, 8'd0,   32'sd0,         7'd64, 1'b0, '0, ST_OK, '0},
        '{OP_GET,    8'd0,   32'sd0,         7'd1,  1'b1, ERR_WORD, ST_RANGE, 7'd0}
    };

    // ------------------------------------------------------------------------
    // main sequence: reset, directed table, random traffic, drain, verdict
    // ------------------------------------------------------------------------
    initial
    begin
        dir_row_t  row;
        list_rsp_t row_rsp;
        list_rsp_t no_rsp;
        lean_t     lean;
        int        phase_left;
        op_t       op;
        pos_t      pos;
        word_t     val;

        list_len   = 0;
        fail_count = 0;
        burst_left = 0;
        phase_left = 0;
        lean       = LEAN_EVEN;
        no_rsp     = '0;

        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_APPEND;
        req_ch.position  <= '0;
        req_ch.value     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = directed_rows[r];
            row_rsp.data   = row.data;
            row_rsp.status = row.status;
            row_rsp.count  = row.count;
            for (int k = 0; k < int'(row.reps); k++)
                send_request(row.op, row.pos, word_t'(row.value + k), row.known, row_rsp);
        end

        // random traffic in phases of growing, shrinking or even mix
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                lean       = lean_t'($urandom_range(LEAN_GROW, LEAN_EVEN));
                phase_left = $urandom_range(40, 150);
            end
            phase_left--;
            pick_request(list_len, lean, op, pos, val);
            send_request(op, pos, val, 1'b0, no_rsp);
        end
        req_ch.valid <= 1'b0;

        // wait for every owed beat, then a little longer for strays
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("indexed_list_insert_delete: match");
        else
            $display("indexed_list_insert_delete: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // response ready: segments of random length, each with its own pattern
    // ------------------------------------------------------------------------
    initial
    begin
        rdy_mode_t mode;
        int        seg;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = rdy_mode_t'($urandom_range(RDY_ALWAYS, RDY_SPARSE));
            seg  = $urandom_range(16, 160);
            repeat (seg)
            begin
                @(posedge clk);
                case (mode)
                    RDY_ALWAYS: rsp_ch.ready <= 1'b1;
                    RDY_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    RDY_HALF:   rsp_ch.ready <= ($urandom_range(0, 1) != 0);
                    default:    rsp_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // response checker: each accepted beat against the oldest owed response
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected response beat: data %h status %0d count %0d",
                       rsp_ch.data, rsp_ch.status, rsp_ch.count);
                fail_count++;
            end
            else
            begin
                rsp_want = pending_rsp.pop_front();
                if (rsp_ch.data !== rsp_want.data)
                begin
                    $error("data: expected %h, got %h", rsp_want.data, rsp_ch.data);
                    fail_count++;
                end
                if (rsp_ch.status !== rsp_want.status)
                begin
                    $error("status: expected %0d, got %0d", rsp_want.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.count !== rsp_want.count)
                begin
                    $error("count: expected %0d, got %0d", rsp_want.count, rsp_ch.count);
                    fail_count++;
                end
            end
        end
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("indexed_list_insert_delete: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ilid_pkg.sv
rtl/ilid_if.sv
rtl/ilid_ram.sv
rtl/indexed_list_insert_delete.sv
tb/indexed_list_insert_delete_tb.sv
